// File: rtl/core/wrs_pkg.sv
`default_nettype none

package wrs_pkg;

    // Width of the random number that a choose request carries.
    localparam int RND_W = 32;

    // Width of the weight field on the request port.
    localparam int IN_WEIGHT_W = 16;

    // Width of the index field on the result port.
    localparam int OUT_INDEX_W = 6;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_CHOOSE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/wrs_ram.sv
`default_nettype none

module wrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/wrs_mod.sv
`default_nettype none

module wrs_mod #(
    parameter int DIV_W = 22
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [wrs_pkg::RND_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]          divisor,
    output logic                           done,
    output logic      [DIV_W-1:0]          remainder
);

    import wrs_pkg::*;

    localparam int STEP_W = $clog2(RND_W + 1);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RND_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic [DIV_W-1:0]  rem_next;

    // One restoring step per cycle: bring in the next dividend bit and
    // subtract the divisor when it fits. The remainder stays below the divisor.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[RND_W-1]};
        diff     = trial - {1'b0, div_reg};
        rem_next = (trial >= {1'b0, div_reg}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(RND_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/weighted_random_selector.sv
// Clear, append and unused requests, and a choose on an empty table or a zero total,
// give their result beat the cycle after a request is taken; a new request is taken then.
// Other chooses run 32 divider steps, hand the remainder on, then test one entry per cycle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the entry count and the running total; the weight memory is not cleared.
`default_nettype none

module weighted_random_selector #(
    parameter int MAX_ENTRIES = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      req_type,
    input  wire logic [wrs_pkg::IN_WEIGHT_W-1:0] entry_weight,
    input  wire logic [wrs_pkg::RND_W-1:0]       random_value,
    output logic                                 done,
    output logic      [1:0]                      status,
    output logic      [wrs_pkg::OUT_INDEX_W-1:0] chosen_index
);

    import wrs_pkg::*;

    // Index into the weight memory, a count that can reach the table size,
    // and a total wide enough for a full table of maximal weights.
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int TOT_W = WEIGHT_BITS + IDX_W;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [TOT_W-1:0]       total_reg;
    logic [TOT_W-1:0]       total_next;
    logic [TOT_W-1:0]       rem_reg;
    logic [TOT_W-1:0]       rem_next;
    logic [IDX_W-1:0]       walk_reg;
    logic [IDX_W-1:0]       walk_next;
    logic                   done_reg;
    logic                   done_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [IDX_W-1:0]       index_reg;
    logic [IDX_W-1:0]       index_next;

    logic                   accept;
    logic                   table_full;
    logic [WEIGHT_BITS+IN_WEIGHT_W-1:0] weight_ext;
    logic [WEIGHT_BITS-1:0] new_weight;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [WEIGHT_BITS-1:0] ram_rd_data;
    logic [TOT_W-1:0]       entry_w;
    logic                   walk_last;
    logic                   mod_start;
    logic                   mod_done;
    logic [TOT_W-1:0]       mod_rem;
    logic [IDX_W+OUT_INDEX_W-1:0] index_ext;

    assign accept     = start && !busy;
    assign busy       = (state_reg != ST_IDLE);
    assign table_full = (count_reg == CNT_W'(MAX_ENTRIES));

    // The weight is kept in its low WEIGHT_BITS bits, zero-extended when the
    // stored width exceeds the port width.
    assign weight_ext = {{WEIGHT_BITS{1'b0}}, entry_weight};
    assign new_weight = weight_ext[WEIGHT_BITS-1:0];

    // The weight of the entry currently presented by the memory, at total width.
    assign entry_w   = {{(TOT_W-WEIGHT_BITS){1'b0}}, ram_rd_data};
    assign walk_last = ((CNT_W'(walk_reg) + 1'b1) == count_reg);

    assign ram_we = accept && (req_type == REQ_APPEND) && !table_full;

    wrs_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_weight_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (new_weight),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The divider is started only when the total is nonzero.
    assign mod_start = accept && (req_type == REQ_CHOOSE) &&
                       (count_reg != '0) && (total_reg != '0);

    wrs_mod #(
        .DIV_W (TOT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (random_value),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        rem_next    = rem_reg;
        walk_next   = walk_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        ram_rd_addr = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Entry 0 is read while the divider runs, so its weight is
                // already on the memory output when the walk begins.
                if (accept)
                begin
                    status_next = STAT_OK;
                    index_next  = '0;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                            done_next  = 1'b1;
                        end
                        REQ_APPEND:
                        begin
                            if (table_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                total_next = total_reg +
                                             {{(TOT_W-WEIGHT_BITS){1'b0}}, new_weight};
                            end
                            done_next = 1'b1;
                        end
                        REQ_CHOOSE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                done_next   = 1'b1;
                            end
                            else if (total_reg == '0)
                            begin
                                // All weights are zero: entry 0 is picked.
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_MOD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_MOD:
            begin
                if (mod_done)
                begin
                    rem_next   = mod_rem;
                    walk_next  = '0;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                // The memory presents the weight of the entry under test while
                // the next entry is being read, so one entry is tested a cycle.
                ram_rd_addr = walk_reg + 1'b1;
                if ((rem_reg < entry_w) || walk_last)
                begin
                    index_next  = walk_reg;
                    status_next = STAT_OK;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rem_next  = rem_reg - entry_w;
                    walk_next = walk_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            total_reg  <= total_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        walk_reg   <= walk_next;
        status_reg <= status_next;
        index_reg  <= index_next;
    end

    // The result port carries the low bits of the index.
    assign index_ext    = {{OUT_INDEX_W{1'b0}}, index_reg};
    assign done         = done_reg;
    assign status       = status_reg;
    assign chosen_index = index_ext[OUT_INDEX_W-1:0];

endmodule

`default_nettype wire

// File: tb/sv/weighted_random_selector_tb.sv
`timescale 1ns / 1ps

module weighted_random_selector_tb;

    import wrs_pkg::*;

    // Table geometry of the instance under test (the block's defaults).
    localparam int MAX_ENTRIES = 64;

    // A choose runs the divider and then walks the live entries, so a stretch far
    // longer than any choose with no beat in either direction means the block hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int SCRIPT_ROWS    = 25;

    // One outcome of a request: what the block must report for it.
    typedef struct packed {
        stat_t      status;
        logic [5:0] index;
    } draw_t;

    // One row of the directed script. When pinned is set, the outcome is the
    // typed-in one; otherwise it comes from the lottery model below.
    typedef struct packed {
        req_t        req;
        logic [15:0] weight;
        logic [31:0] rnd;
        logic [6:0]  reps;
        logic        pinned;
        stat_t       status;
        logic [5:0]  index;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [15:0] entry_weight;
    logic [31:0] random_value;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  chosen_index;

    // Typed-in outcome travelling with the beat that is being offered.
    logic        pin_on;
    stat_t       pin_status;
    logic [5:0]  pin_index;

    // Our own copy of the lottery state: stored weights, how many are live,
    // and their running sum.
    logic [15:0]     bank_weight [MAX_ENTRIES];
    int unsigned     bank_count;
    longint unsigned bank_total;

    // Outcomes owed by the block, oldest first.
    draw_t draws_owed[$];

    int gap_pct;
    int issued;
    int fails;
    int checked;
    int idle_cycles;
    int n_clear, n_append, n_choose, n_unused, n_full, n_empty;
    int deepest_pick;

    // The directed script. It starts on an empty table, hits the zero-total
    // choose, fills the table to the brim, knocks on it twice when full and
    // then picks the first and the very last entry.
    script_row_t script [SCRIPT_ROWS] = '{
        // Choose right after reset: nothing stored yet.
        '{REQ_CHOOSE, 16'h0000, 32'h0000_0000, 7'd1,  1'b1, STAT_EMPTY, 6'd0},
        '{REQ_CHOOSE, 16'hFFFF, 32'hFFFF_FFFF, 7'd1,  1'b1, STAT_EMPTY, 6'd0},
        // The unused request code does nothing and still answers OK.
        '{REQ_NONE,   16'hFFFF, 32'hFFFF_FFFF, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_APPEND, 16'h0000, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        // A single zero weight gives a zero total, which must pick entry 0.
        '{REQ_CHOOSE, 16'h0000, 32'hFFFF_FFFF, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_APPEND, 16'h0000, 32'hFFFF_FFFF, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_APPEND, 16'hFFFF, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_CHOOSE, 16'h0000, 32'h0000_0000, 7'd1,  1'b0, STAT_OK,    6'd0},
        '{REQ_CHOOSE, 16'h0000, 32'hFFFF_FFFF, 7'd1,  1'b0, STAT_OK,    6'd0},
        '{REQ_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_CHOOSE, 16'h0000, 32'h1234_5678, 7'd1,  1'b1, STAT_EMPTY, 6'd0},
        // Fill every slot with the largest weight.
        '{REQ_APPEND, 16'hFFFF, 32'h0000_0000, 7'd64, 1'b1, STAT_OK,    6'd0},
        // Appends to a full table are dropped.
        '{REQ_APPEND, 16'h0001, 32'h0000_0000, 7'd1,  1'b1, STAT_FULL,  6'd0},
        '{REQ_APPEND, 16'h0000, 32'hFFFF_FFFF, 7'd1,  1'b1, STAT_FULL,  6'd0},
        '{REQ_NONE,   16'h0000, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        // Remainder zero lands on the first entry, total minus one on the last.
        '{REQ_CHOOSE, 16'h0000, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_CHOOSE, 16'h0000, 32'd4194239,   7'd1,  1'b1, STAT_OK,    6'd63},
        '{REQ_CHOOSE, 16'h0000, 32'hFFFF_FFFF, 7'd1,  1'b0, STAT_OK,    6'd0},
        '{REQ_CHOOSE, 16'hFFFF, 32'hAAAA_5555, 7'd1,  1'b0, STAT_OK,    6'd0},
        '{REQ_CLEAR,  16'h0000, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        // Zero-weight entries around live ones must be walked past.
        '{REQ_APPEND, 16'h0000, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_APPEND, 16'h0005, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_APPEND, 16'h0000, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_APPEND, 16'h0003, 32'h0000_0000, 7'd1,  1'b1, STAT_OK,    6'd0},
        '{REQ_CHOOSE, 16'h0000, 32'd5,         7'd1,  1'b0, STAT_OK,    6'd0}
    };

    weighted_random_selector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .entry_weight (entry_weight),
        .random_value (random_value),
        .done         (done),
        .status       (status),
        .chosen_index (chosen_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one request to the lottery state and returns what the block must
    // answer. A choose reduces the random number by the total, then walks the
    // live entries subtracting weights until the remainder fits in one.
    function automatic draw_t lottery_draw(req_t req, logic [15:0] w, logic [31:0] rnd);
        draw_t           d;
        longint unsigned rem;
        bit              found;
        d.status = STAT_OK;
        d.index  = '0;
        found    = 1'b0;
        case (req)
            REQ_CLEAR:
            begin
                // Old weights stay in the array but are never read again.
                bank_count = 0;
                bank_total = 0;
            end
            REQ_APPEND:
            begin
                if (bank_count >= MAX_ENTRIES)
                begin
                    d.status = STAT_FULL;
                end
                else
                begin
                    bank_weight[bank_count] = w;
                    bank_count++;
                    bank_total += w;
                end
            end
            REQ_CHOOSE:
            begin
                if (bank_count == 0)
                begin
                    d.status = STAT_EMPTY;
                end
                else if (bank_total != 0)
                begin
                    rem = rnd % bank_total;
                    for (int i = 0; i < bank_count && !found; i++)
                    begin
                        if (rem < bank_weight[i])
                        begin
                            d.index = 6'(i);
                            found   = 1'b1;
                        end
                        else
                        begin
                            rem -= bank_weight[i];
                        end
                    end
                end
                // A zero total leaves the index at entry 0.
            end
            default: ;
        endcase
        return d;
    endfunction

    // Weight patterns for one table build: anything, tiny, mostly zero, or
    // crowded at the top of the range.
    function automatic logic [15:0] rand_weight(int style);
        case (style)
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(7));
            2:       return ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0000;
            default: return 16'hFFFF - 16'($urandom_range(3));
        endcase
    endfunction

    // Random numbers for a choose. Some are aimed just under the current total
    // so that the walk runs to the last live entries.
    function automatic logic [31:0] pick_rnd();
        case ($urandom_range(4))
            0, 1: return $urandom;
            2:    return $urandom_range(31);
            3:    return (bank_total > 2) ? 32'(bank_total - 1 - $urandom_range(2))
                                          : 32'hFFFF_FFFF;
            default: return 32'hFFFF_FFFF - $urandom_range(7);
        endcase
    endfunction

    // Offers one request beat and returns at the falling edge after it was
    // taken. It is entered at a falling edge, and start is only lowered when a
    // gap is wanted, so back-to-back beats keep start high.
    task automatic issue(req_t r, logic [15:0] w, logic [31:0] rnd,
                         logic pin, stat_t ps, logic [5:0] pi);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < gap_pct);
        end
        start        <= 1'b1;
        req_type     <= r;
        entry_weight <= w;
        random_value <= rnd;
        pin_on       <= pin;
        pin_status   <= ps;
        pin_index    <= pi;
        // busy read here is the value that the edge itself saw.
        do @(posedge clk); while (busy);
        issued++;
        @(negedge clk);
    endtask

    // Watches both sides at every rising edge: a taken request adds its outcome
    // to the owed list, a result beat is checked against the oldest one.
    always @(posedge clk)
    begin
        draw_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = lottery_draw(req_t'(req_type), entry_weight, random_value);
                if (pin_on)
                begin
                    want.status = pin_status;
                    want.index  = pin_index;
                end
                draws_owed.push_back(want);
                case (req_t'(req_type))
                    REQ_CLEAR:  n_clear++;
                    REQ_APPEND: n_append++;
                    REQ_CHOOSE: n_choose++;
                    default:    n_unused++;
                endcase
                if (want.status == STAT_FULL)
                    n_full++;
                if (want.status == STAT_EMPTY)
                    n_empty++;
            end
            if (done)
            begin
                if (draws_owed.size() == 0)
                begin
                    $error("result beat with nothing outstanding: status %0d, chosen_index %0d",
                           status, chosen_index);
                    fails++;
                end
                else
                begin
                    want = draws_owed.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fails++;
                    end
                    if (chosen_index !== want.index)
                    begin
                        $error("chosen_index: expected %0d, got %0d", want.index, chosen_index);
                        fails++;
                    end
                    checked++;
                    if (int'(chosen_index) > deepest_pick)
                        deepest_pick = chosen_index;
                end
            end
        end
    end

    // Hang detector: any beat in either direction restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles, %0d results still owed",
                         WATCHDOG_LIMIT, draws_owed.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        int style;
        int n;
        int target;
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_CLEAR;
        entry_weight = '0;
        random_value = '0;
        pin_on       = 1'b0;
        pin_status   = STAT_OK;
        pin_index    = '0;
        bank_count   = 0;
        bank_total   = 0;
        gap_pct      = 7;
        issued       = 0;
        fails        = 0;
        checked      = 0;
        idle_cycles  = 0;
        n_clear      = 0;
        n_append     = 0;
        n_choose     = 0;
        n_unused     = 0;
        n_full       = 0;
        n_empty      = 0;
        deepest_pick = 0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            bank_weight[i] = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed script first, with the light sender gaps of the first phase.
        for (int r = 0; r < SCRIPT_ROWS; r++)
        begin
            for (int k = 0; k < script[r].reps; k++)
                issue(script[r].req, script[r].weight, script[r].rnd,
                      script[r].pinned, script[r].status, script[r].index);
        end

        // Random part in three phases: light gaps, heavy gaps, then none.
        // Most of it builds a fresh table and then draws from it; the rest
        // extends or draws from whatever is stored, or throws in odd requests.
        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 7 : (phase == 1) ? 52 : 0;
            target  = issued + 115;
            while (issued < target)
            begin
                kind = $urandom_range(99);
                if (kind < 75)
                begin
                    issue(REQ_CLEAR, 16'($urandom), $urandom, 1'b0, STAT_OK, '0);
                    style = $urandom_range(3);
                    // Now and then build past the top to hit the full table.
                    n = ($urandom_range(9) == 0) ? $urandom_range(60, 70)
                                                 : $urandom_range(1, 12);
                    repeat (n)
                        issue(REQ_APPEND, rand_weight(style), $urandom, 1'b0, STAT_OK, '0);
                    repeat ($urandom_range(2, 8))
                        issue(REQ_CHOOSE, 16'($urandom), pick_rnd(), 1'b0, STAT_OK, '0);
                end
                else if (kind < 90)
                begin
                    repeat ($urandom_range(1, 4))
                        issue(REQ_APPEND, rand_weight($urandom_range(3)), $urandom,
                              1'b0, STAT_OK, '0);
                    repeat ($urandom_range(1, 4))
                        issue(REQ_CHOOSE, 16'($urandom), pick_rnd(), 1'b0, STAT_OK, '0);
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        issue(req_t'($urandom_range(3)), 16'($urandom), $urandom,
                              1'b0, STAT_OK, '0);
                end
            end
        end
        start <= 1'b0;

        // Let every owed outcome arrive, then watch a little longer for
        // stray result beats.
        while (draws_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: %0d clear, %0d append, %0d choose, %0d unused",
                 issued, n_clear, n_append, n_choose, n_unused);
        $display("%0d results checked, %0d full refusals, %0d empty draws, deepest pick %0d",
                 checked, n_full, n_empty, deepest_pick);
        if (fails == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
